FILE: rtl/vertex_morph_offset_store_defines.svh
// ----------------------------------------------------------------------------
// vertex_morph_offset_store_defines
// Assertion macros shared by the offset store RTL.
// ----------------------------------------------------------------------------
`ifndef VERTEX_MORPH_OFFSET_STORE_DEFINES_SVH
`define VERTEX_MORPH_OFFSET_STORE_DEFINES_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define VMOS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vmos assertion failed");

// antecedent implies consequent in the next cycle
`define VMOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vmos assertion failed");

`else

`define VMOS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define VMOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/vmos_pkg.sv
// ----------------------------------------------------------------------------
// vmos_pkg
// Types, widths, codes and helpers of the vertex morph offset store.
// ----------------------------------------------------------------------------
package vmos_pkg;

	// field widths
	localparam int VAL_W   = 24;
	localparam int KIND_W  = 2;
	localparam int GRP_W   = 2;
	localparam int CH_W    = 3;
	localparam int VTX_W   = 8;
	localparam int WGT_W   = 17;
	localparam int MASK_W  = 7;
	localparam int NCOMP   = 4;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam int WEIGHT_ONE = 65536;

	// default sizes
	localparam int VERTICES_DEF = 256;
	localparam int GROUPS_DEF   = 4;
	localparam int UV_SETS_DEF  = 4;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BLEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// channels
	localparam logic [CH_W-1:0] CH_POS = 3'd0;
	localparam logic [CH_W-1:0] CH_NRM = 3'd1;
	localparam logic [CH_W-1:0] CH_COL = 3'd2;

	// interpolate_enable bit positions
	localparam logic [CH_W-1:0] EN_BIT_COL = 3'd0;
	localparam logic [CH_W-1:0] EN_BIT_POS = 3'd1;
	localparam logic [CH_W-1:0] EN_BIT_NRM = 3'd2;

	// register select (paddr bit 2)
	localparam logic REG_INTERP_EN  = 1'b0;
	localparam logic REG_AUTO_CLEAR = 1'b1;

	typedef logic [VAL_W-1:0] comp_t;
	typedef comp_t [NCOMP-1:0] elem_t;

	// components used by a channel
	function automatic logic [2:0] comp_count(input logic [CH_W-1:0] ch);
		logic [2:0] n;
		if (ch == CH_POS || ch == CH_NRM) n = 3'd3;
		else if (ch == CH_COL) n = 3'd4;
		else n = 3'd2;
		return n;
	endfunction

	// bit of interpolate_enable that gates a channel
	function automatic logic [CH_W-1:0] enable_bit(input logic [CH_W-1:0] ch);
		logic [CH_W-1:0] b;
		if (ch == CH_POS) b = EN_BIT_POS;
		else if (ch == CH_NRM) b = EN_BIT_NRM;
		else if (ch == CH_COL) b = EN_BIT_COL;
		else b = ch;
		return b;
	endfunction

endpackage

FILE: rtl/vmos_item_if.sv
// ----------------------------------------------------------------------------
// vmos_item_if
// Input item channel of the offset store: valid/ready with payload.
// ----------------------------------------------------------------------------
interface vmos_item_if;
	logic                                  valid;
	logic                                  ready;
	logic [vmos_pkg::KIND_W-1:0]           kind;
	logic                                  start_of_key;
	logic [vmos_pkg::GRP_W-1:0]            group_index;
	logic [vmos_pkg::CH_W-1:0]             channel;
	logic [vmos_pkg::VTX_W-1:0]            vertex_index;
	logic signed [vmos_pkg::VAL_W-1:0]     value_a;
	logic signed [vmos_pkg::VAL_W-1:0]     value_b;
	logic signed [vmos_pkg::VAL_W-1:0]     value_c;
	logic signed [vmos_pkg::VAL_W-1:0]     value_d;
	logic [vmos_pkg::WGT_W-1:0]            blend_weight;

	modport source (
		output valid, kind, start_of_key, group_index, channel, vertex_index,
		       value_a, value_b, value_c, value_d, blend_weight,
		input  ready
	);

	modport sink (
		input  valid, kind, start_of_key, group_index, channel, vertex_index,
		       value_a, value_b, value_c, value_d, blend_weight,
		output ready
	);
endinterface

FILE: rtl/vmos_result_if.sv
// ----------------------------------------------------------------------------
// vmos_result_if
// Result channel of the offset store: valid/ready with payload.
// ----------------------------------------------------------------------------
interface vmos_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [vmos_pkg::VAL_W-1:0]     out_a;
	logic signed [vmos_pkg::VAL_W-1:0]     out_b;
	logic signed [vmos_pkg::VAL_W-1:0]     out_c;
	logic signed [vmos_pkg::VAL_W-1:0]     out_d;
	logic [vmos_pkg::MASK_W-1:0]           active_mask;
	logic                                  written;

	modport source (
		output valid, out_a, out_b, out_c, out_d, active_mask, written,
		input  ready
	);

	modport sink (
		input  valid, out_a, out_b, out_c, out_d, active_mask, written,
		output ready
	);
endinterface

FILE: rtl/vmos_blend.sv
// ----------------------------------------------------------------------------
// vmos_blend
// Four-lane blend unit: registered (target - value) * weight, then a
// truncating scale by 1/65536 and the add back onto the stored value.
// ----------------------------------------------------------------------------
module vmos_blend (
	input  logic                          clk,
	input  logic                          load,
	input  vmos_pkg::elem_t               el,
	input  vmos_pkg::elem_t               tgt,
	input  logic [vmos_pkg::WGT_W-1:0]    weight,
	input  logic                          colour,
	output vmos_pkg::elem_t               blend_el
);
	localparam int DIFF_W = vmos_pkg::VAL_W + 1;
	localparam int WT_W   = vmos_pkg::WGT_W + 1;
	localparam int PROD_W = DIFF_W + WT_W;
	localparam int SHIFT  = 16;
	localparam int STEP_W = PROD_W - SHIFT;
	localparam int COL_W  = 16;

	function automatic logic signed [DIFF_W-1:0] diff_of(
		input vmos_pkg::comp_t a,
		input vmos_pkg::comp_t b
	);
		logic signed [DIFF_W-1:0] d;
		d = $signed({a[vmos_pkg::VAL_W-1], a}) - $signed({b[vmos_pkg::VAL_W-1], b});
		return d;
	endfunction

	logic signed [PROD_W-1:0] wprod_s2 [vmos_pkg::NCOMP];

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < vmos_pkg::NCOMP; k++) begin
				wprod_s2[k] <= diff_of(tgt[k], el[k]) * $signed({1'b0, weight});
			end
		end
	end

	always_comb begin
		logic [PROD_W-1:0] biased;
		logic [STEP_W-1:0] step;
		logic [COL_W-1:0]  csum;
		for (int k = 0; k < vmos_pkg::NCOMP; k++) begin
			// round toward zero: bias negative products before the shift
			biased = wprod_s2[k][PROD_W-1]
				? PROD_W'(wprod_s2[k]) + PROD_W'((1 << SHIFT) - 1)
				: PROD_W'(wprod_s2[k]);
			step = biased[PROD_W-1:SHIFT];
			csum = el[k][COL_W-1:0] + step[COL_W-1:0];
			if (colour) begin
				blend_el[k] = {{(vmos_pkg::VAL_W-COL_W){csum[COL_W-1]}}, csum};
			end else begin
				blend_el[k] = el[k] + step[vmos_pkg::VAL_W-1:0];
			end
		end
	end

endmodule

FILE: rtl/vertex_morph_offset_store.sv
// ----------------------------------------------------------------------------
// vertex_morph_offset_store
// Per-vertex morph offsets for mesh groups, held in one synchronous RAM of
// four-component elements; set, blend, clear and read items.
// ----------------------------------------------------------------------------
// Items are accepted only in idle; the RAM read, the blend multiply stage
// and the write-back follow in turn before the next item is accepted, and
// the write-back waits while the held result is not taken. A set or enabled
// blend on a channel not active in its group first zeroes that row. Clear
// and auto clear only drop mask bits and do not sweep the RAM. Reset clears
// masks and control, clears interpolate_enable and sets auto clear; the RAM
// is not swept: an inactive row reads zero until its first write zeroes it.
// ----------------------------------------------------------------------------
`include "vertex_morph_offset_store_defines.svh"

module vertex_morph_offset_store #(
	parameter int VERTICES = vmos_pkg::VERTICES_DEF,
	parameter int GROUPS   = vmos_pkg::GROUPS_DEF,
	parameter int UV_SETS  = vmos_pkg::UV_SETS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	vmos_item_if.sink                     item,
	vmos_result_if.source                 result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [vmos_pkg::APB_AW-1:0]   paddr,
	input  logic [vmos_pkg::APB_DW-1:0]   pwdata,
	output logic [vmos_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	localparam int CHANNELS = 3 + UV_SETS;
	localparam int GW       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int VW       = (VERTICES > 1) ? $clog2(VERTICES) : 1;
	localparam int AW       = GW + vmos_pkg::CH_W + VW;
	localparam int DEPTH    = 1 << AW;
	localparam int ELEM_W   = vmos_pkg::NCOMP * vmos_pkg::VAL_W;
	localparam int MW       = vmos_pkg::MASK_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_WB    = 3'd4;

	// configuration
	logic [MW-1:0] interp_q;
	logic          auto_clear_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_q     <= '0;
			auto_clear_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				vmos_pkg::REG_INTERP_EN:  interp_q     <= pwdata[MW-1:0];
				vmos_pkg::REG_AUTO_CLEAR: auto_clear_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			vmos_pkg::REG_INTERP_EN:  prdata = {{(vmos_pkg::APB_DW-MW){1'b0}}, interp_q};
			vmos_pkg::REG_AUTO_CLEAR: prdata = {{(vmos_pkg::APB_DW-1){1'b0}}, auto_clear_q};
			default:                  prdata = '0;
		endcase
	end

	// control state
	logic [2:0]    state_q;
	logic [VW-1:0] sweep_q;
	logic [MW-1:0] mask_q [GROUPS];
	logic          res_valid_q;

	// item registers
	logic [vmos_pkg::KIND_W-1:0] kind_q;
	logic [GW-1:0]               gi_q;
	logic [vmos_pkg::CH_W-1:0]   ch_q;
	logic [VW-1:0]               v_q;
	vmos_pkg::elem_t             tgt_q;
	logic [vmos_pkg::WGT_W-1:0]  w_q;
	logic                        gok_q;
	logic                        eok_q;
	logic                        wr_q;
	logic                        colour_q;

	// result registers
	vmos_pkg::elem_t             res_el_q;
	logic [MW-1:0]               res_mask_q;
	logic                        res_written_q;

	// accept-side decode
	logic                        accept;
	logic                        in_gok;
	logic                        in_eok;
	logic [GW-1:0]               in_gi;
	logic [MW-1:0]               mask_in;
	logic [MW-1:0]               mask_eff;
	logic [MW:0]                 mask_eff_x;
	logic [MW:0]                 interp_x;
	logic                        in_wr;
	logic                        in_act;
	vmos_pkg::elem_t             in_tgt;
	logic [vmos_pkg::WGT_W-1:0]  in_w;

	assign accept   = item.valid && item.ready;
	assign in_gok   = 32'(item.group_index) < GROUPS;
	assign in_eok   = (32'(item.channel) < CHANNELS) && (32'(item.vertex_index) < VERTICES);
	assign in_gi    = GW'(item.group_index);
	assign mask_in  = in_gok ? mask_q[in_gi] : '0;
	assign mask_eff = ((item.start_of_key && auto_clear_q)
		|| item.kind == vmos_pkg::KIND_CLEAR) ? '0 : mask_in;
	assign mask_eff_x = {1'b0, mask_eff};
	assign interp_x   = {1'b0, interp_q};
	assign in_act     = mask_eff_x[item.channel];
	assign in_wr      = in_gok && in_eok && ((item.kind == vmos_pkg::KIND_SET)
		|| (item.kind == vmos_pkg::KIND_BLEND
		    && interp_x[vmos_pkg::enable_bit(item.channel)]));
	assign in_w = (32'(item.blend_weight) > vmos_pkg::WEIGHT_ONE)
		? vmos_pkg::WGT_W'(vmos_pkg::WEIGHT_ONE) : item.blend_weight;

	always_comb begin
		in_tgt[0] = item.value_a;
		in_tgt[1] = item.value_b;
		in_tgt[2] = item.value_c;
		in_tgt[3] = item.value_d;
		// colour wraps at 16 bits
		if (item.channel == vmos_pkg::CH_COL) begin
			for (int k = 0; k < vmos_pkg::NCOMP; k++) begin
				in_tgt[k] = {{(vmos_pkg::VAL_W-16){in_tgt[k][15]}}, in_tgt[k][15:0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= item.kind;
			gi_q     <= in_gi;
			ch_q     <= item.channel;
			v_q      <= VW'(item.vertex_index);
			tgt_q    <= in_tgt;
			w_q      <= in_w;
			gok_q    <= in_gok;
			eok_q    <= in_eok;
			wr_q     <= in_wr;
			colour_q <= item.channel == vmos_pkg::CH_COL;
		end
	end

	// offset RAM
	logic [ELEM_W-1:0] offset_mem_q [DEPTH];
	logic [ELEM_W-1:0] rdata_q;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_waddr;
	logic [AW-1:0]     mem_raddr;
	logic [ELEM_W-1:0] mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			offset_mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= offset_mem_q[mem_raddr];
		end
	end

	// blend unit
	vmos_pkg::elem_t el;
	vmos_pkg::elem_t blend_el;

	assign el = vmos_pkg::elem_t'(rdata_q);

	vmos_blend u_blend (
		.clk      (clk),
		.load     (state_q == ST_MUL),
		.el       (el),
		.tgt      (tgt_q),
		.weight   (w_q),
		.colour   (colour_q),
		.blend_el (blend_el)
	);

	// write-back decode
	logic              wb_go;
	logic [MW-1:0]     mask_cur;
	logic [MW:0]       mask_cur_x;
	logic              act_cur;
	logic [MW-1:0]     wr_bit;
	logic [2:0]        ncomp;
	vmos_pkg::elem_t   new_el;
	vmos_pkg::elem_t   out_el;

	assign wb_go      = (state_q == ST_WB) && (!res_valid_q || result.ready);
	assign mask_cur   = gok_q ? mask_q[gi_q] : '0;
	assign mask_cur_x = {1'b0, mask_cur};
	assign act_cur    = mask_cur_x[ch_q];
	assign wr_bit     = wr_q ? (MW'(1) << ch_q) : '0;
	assign ncomp      = vmos_pkg::comp_count(ch_q);

	always_comb begin
		for (int k = 0; k < vmos_pkg::NCOMP; k++) begin
			if (3'(k) < ncomp) begin
				new_el[k] = (kind_q == vmos_pkg::KIND_SET) ? tgt_q[k] : blend_el[k];
				out_el[k] = (gok_q && eok_q && (act_cur || wr_q))
					? (wr_q ? new_el[k] : el[k]) : '0;
			end else begin
				new_el[k] = '0;
				out_el[k] = '0;
			end
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {gi_q, ch_q, v_q};
		mem_wdata = ELEM_W'(new_el);
		if (state_q == ST_SWEEP) begin
			mem_we    = 1'b1;
			mem_waddr = {gi_q, ch_q, sweep_q};
			mem_wdata = '0;
		end else if (wb_go && wr_q) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re    = state_q == ST_RD;
	assign mem_raddr = {gi_q, ch_q, v_q};

	assign item.ready = state_q == ST_IDLE;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sweep_q     <= '0;
			res_valid_q <= 1'b0;
			for (int g = 0; g < GROUPS; g++) begin
				mask_q[g] <= '0;
			end
		end else begin
			// a new result beat replaces the one leaving
			if (wb_go) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_gok) begin
							mask_q[in_gi] <= mask_eff;
						end
						sweep_q <= '0;
						// first write to an inactive row zeroes it
						state_q <= (in_wr && !in_act) ? ST_SWEEP : ST_RD;
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + VW'(1);
					if (sweep_q == VW'(VERTICES - 1)) begin
						state_q <= ST_RD;
					end
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_WB;
				ST_WB: begin
					if (wb_go) begin
						if (wr_q) begin
							mask_q[gi_q] <= mask_cur | wr_bit;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			res_el_q      <= out_el;
			res_mask_q    <= gok_q ? (mask_cur | wr_bit) : '0;
			res_written_q <= wr_q;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.out_a       = res_el_q[0];
	assign result.out_b       = res_el_q[1];
	assign result.out_c       = res_el_q[2];
	assign result.out_d       = res_el_q[3];
	assign result.active_mask = res_mask_q;
	assign result.written     = res_written_q;

	`VMOS_ASSERT_IMPLY(a_sweep_inactive_row, clk, arst_n, state_q == ST_SWEEP, !act_cur)
	`VMOS_ASSERT_IMPLY(a_result_from_wb, clk, arst_n, $rose(res_valid_q), $past(state_q) == ST_WB)
	`VMOS_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, state_q == ST_SWEEP || state_q == ST_RD)

endmodule
